>>> hw/rtl/tct_pkg.sv
`timescale 1ns / 1ps
// Package for the triangle collapse time block: default widths, status codes
// and the per-item flag bundle. No dependencies.
package tct_pkg;

	localparam int COORD_WIDTH    = 24;
	localparam int TIME_FRAC_BITS = 16;
	localparam int TIME_WIDTH     = 32;
	// Quotient bits kept before rounding (one guard bit above 32).
	localparam int QUOT_WIDTH     = TIME_WIDTH + 1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_IN    = 2'd1,
		ST_AREA_ZERO = 2'd2,
		ST_DEN_ZERO  = 2'd3
	} tct_status_t;

	localparam logic [1:0] SEL_FIRST  = 2'd0;
	localparam logic [1:0] SEL_SECOND = 2'd1;
	localparam logic [1:0] SEL_THIRD  = 2'd2;
	localparam logic [1:0] SEL_NONE   = 2'd3;

	typedef struct packed {
		tct_status_t status;
		logic        neg;
		logic        sat;
	} tct_flags_t;

endpackage

>>> hw/rtl/tct_req_if.sv
`timescale 1ns / 1ps
// Request channel of the triangle collapse time block: valid/ready and one
// triangle with its moving vertex select and step. Uses tct_pkg.
interface tct_req_if #(parameter int CW = tct_pkg::COORD_WIDTH) ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           moving_sel;
	logic signed [CW-1:0] first_x;
	logic signed [CW-1:0] first_y;
	logic signed [CW-1:0] second_x;
	logic signed [CW-1:0] second_y;
	logic signed [CW-1:0] third_x;
	logic signed [CW-1:0] third_y;
	logic signed [CW-1:0] step_x;
	logic signed [CW-1:0] step_y;

	modport source (output valid, moving_sel, first_x, first_y, second_x, second_y,
		third_x, third_y, step_x, step_y, input ready);
	modport sink (input valid, moving_sel, first_x, first_y, second_x, second_y,
		third_x, third_y, step_x, step_y, output ready);
endinterface

>>> hw/rtl/tct_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the triangle collapse time block: valid/ready, the time
// in fixed point and a status code. Uses tct_pkg.
interface tct_rsp_if ();
	logic                                 valid;
	logic                                 ready;
	logic signed [tct_pkg::TIME_WIDTH-1:0] collapse_time;
	logic [1:0]                           status;

	modport source (output valid, collapse_time, status, input ready);
	modport sink (input valid, collapse_time, status, output ready);
endinterface

>>> hw/rtl/tct_front.sv
`timescale 1ns / 1ps
// Front pipeline: vertex select and shift, the four cross products, start area,
// denominator, magnitudes and the special-case / overflow checks. Uses tct_pkg.
module tct_front #(
	parameter int CW = tct_pkg::COORD_WIDTH,
	parameter int FB = tct_pkg::TIME_FRAC_BITS,
	localparam int NW = 2 * CW + 3,
	localparam int QW = tct_pkg::QUOT_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [1:0]          sel,
	input  logic signed [CW-1:0] x0,
	input  logic signed [CW-1:0] y0,
	input  logic signed [CW-1:0] x1,
	input  logic signed [CW-1:0] y1,
	input  logic signed [CW-1:0] x2,
	input  logic signed [CW-1:0] y2,
	input  logic signed [CW-1:0] dx,
	input  logic signed [CW-1:0] dy,
	output logic                valid_s5,
	output tct_pkg::tct_flags_t flags_s5,
	output logic [NW-1:0]       rem_s5,
	output logic [QW-1:0]       low_s5,
	output logic [NW-1:0]       den_s5
);
	localparam int PW = 2 * CW + 2;
	localparam int SH = tct_pkg::TIME_WIDTH - FB;
	localparam int EW = NW + FB + 1 + QW;

	logic signed [CW-1:0] ax, ay, bx, by, cx, cy;

	logic                valid_s1, valid_s2, valid_s3, valid_s4;
	logic                none_s1, none_s2, none_s3, none_s4;
	logic signed [CW:0]  bx_s1, by_s1, cx_s1, cy_s1;
	logic signed [CW-1:0] dx_s1, dy_s1;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2;
	logic signed [NW-1:0] num_s3, den_s3;
	logic [NW-1:0]       nmag_s4, dmag_s4;
	logic                neg_s4;

	logic [EW-1:0]       nfull;
	logic                ovf;
	tct_pkg::tct_flags_t flags_d;

	// Pick the fixed vertices A, B and the moving vertex C
	always_comb begin
		unique case (sel)
			tct_pkg::SEL_FIRST: begin
				ax = x1; ay = y1; bx = x2; by = y2; cx = x0; cy = y0;
			end
			tct_pkg::SEL_SECOND: begin
				ax = x0; ay = y0; bx = x2; by = y2; cx = x1; cy = y1;
			end
			default: begin
				ax = x0; ay = y0; bx = x1; by = y1; cx = x2; cy = y2;
			end
		endcase
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Magnitude scaled by the fraction bits plus one rounding bit
	assign nfull = EW'(nmag_s4) << (FB + 1);
	// Quotient would need more than QW bits: saturate
	assign ovf = {{SH{1'b0}}, nmag_s4} >= {dmag_s4, {SH{1'b0}}};

	always_comb begin
		flags_d.neg = neg_s4;
		flags_d.sat = ovf;
		priority if (none_s4)
			flags_d.status = tct_pkg::ST_NOT_IN;
		else if (nmag_s4 == '0)
			flags_d.status = tct_pkg::ST_AREA_ZERO;
		else if (dmag_s4 == '0)
			flags_d.status = tct_pkg::ST_DEN_ZERO;
		else
			flags_d.status = tct_pkg::ST_OK;
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			// shift A to the origin
			none_s1 <= (sel == tct_pkg::SEL_NONE);
			bx_s1   <= (CW+1)'(bx) - (CW+1)'(ax);
			by_s1   <= (CW+1)'(by) - (CW+1)'(ay);
			cx_s1   <= (CW+1)'(cx) - (CW+1)'(ax);
			cy_s1   <= (CW+1)'(cy) - (CW+1)'(ay);
			dx_s1   <= dx;
			dy_s1   <= dy;
			// cross products
			none_s2 <= none_s1;
			p0_s2   <= PW'(cx_s1) * PW'(by_s1);
			p1_s2   <= PW'(cy_s1) * PW'(bx_s1);
			p2_s2   <= PW'(bx_s1) * PW'(dy_s1);
			p3_s2   <= PW'(by_s1) * PW'(dx_s1);
			// start area and denominator
			none_s3 <= none_s2;
			num_s3  <= NW'(p0_s2) - NW'(p1_s2);
			den_s3  <= NW'(p2_s2) - NW'(p3_s2);
			// magnitudes and sign of the quotient
			none_s4 <= none_s3;
			nmag_s4 <= num_s3[NW-1] ? NW'(-num_s3) : NW'(num_s3);
			dmag_s4 <= den_s3[NW-1] ? NW'(-den_s3) : NW'(den_s3);
			neg_s4  <= num_s3[NW-1] ^ den_s3[NW-1];
			// classify and split dividend for the divider
			flags_s5 <= flags_d;
			rem_s5   <= nfull[NW+QW-1:QW];
			low_s5   <= nfull[QW-1:0];
			den_s5   <= dmag_s4;
		end
	end

endmodule

>>> hw/rtl/tct_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per register stage, flags
// travel alongside. Uses tct_pkg.
module tct_div #(
	parameter int NW = 51,
	localparam int QW = tct_pkg::QUOT_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  tct_pkg::tct_flags_t in_flags,
	input  logic [NW-1:0]       in_rem,
	input  logic [QW-1:0]       in_low,
	input  logic [NW-1:0]       in_den,
	output logic                out_valid,
	output tct_pkg::tct_flags_t out_flags,
	output logic [QW-1:0]       out_quot
);
	logic                valid_s [0:QW];
	tct_pkg::tct_flags_t flags_s [0:QW];
	logic [NW-1:0]       rem_s   [0:QW];
	logic [QW-1:0]       low_s   [0:QW];
	logic [NW-1:0]       den_s   [0:QW];
	logic [QW-1:0]       quot_s  [0:QW];

	assign valid_s[0] = in_valid;
	assign flags_s[0] = in_flags;
	assign rem_s[0]   = in_rem;
	assign low_s[0]   = in_low;
	assign den_s[0]   = in_den;
	assign quot_s[0]  = '0;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [NW:0] trial;
		logic        fits;

		// Bring down the next dividend bit and try the subtract
		assign trial = {rem_s[k], low_s[k][QW-1]};
		assign fits  = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				flags_s[k+1] <= flags_s[k];
				den_s[k+1]   <= den_s[k];
				low_s[k+1]   <= {low_s[k][QW-2:0], 1'b0};
				rem_s[k+1]   <= fits ? NW'(trial - {1'b0, den_s[k]}) : NW'(trial);
				quot_s[k+1]  <= {quot_s[k][QW-2:0], fits};
			end
		end
	end

	assign out_valid = valid_s[QW];
	assign out_flags = flags_s[QW];
	assign out_quot  = quot_s[QW];

endmodule

>>> hw/rtl/triangle_collapse_time.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload
// req      in   moving_sel, first/second/third x,y, step_x, step_y
// rsp      out  collapse_time (signed Q15.16 at default), status
//
// One triangle per cycle unless rsp.ready stalls the pipeline; the path is five front stages
// (select, products, areas, magnitudes, checks), one stage per quotient bit of
// the 33-bit divider, and the output register.
// arst_n clears all valid bits; payload registers are not reset.
// The whole pipeline holds while a result waits and rsp.ready is low.
// Top level of the triangle collapse time block; uses tct_pkg, tct_front,
// tct_div and the tct_req_if / tct_rsp_if channels.
module triangle_collapse_time #(
	parameter int COORD_WIDTH    = tct_pkg::COORD_WIDTH,
	parameter int TIME_FRAC_BITS = tct_pkg::TIME_FRAC_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	tct_req_if.sink   req,
	tct_rsp_if.source rsp
);
	localparam int NW = 2 * COORD_WIDTH + 3;
	localparam int QW = tct_pkg::QUOT_WIDTH;
	localparam int TW = tct_pkg::TIME_WIDTH;

	logic                en;
	logic                fr_valid;
	tct_pkg::tct_flags_t fr_flags;
	logic [NW-1:0]       fr_rem, fr_den;
	logic [QW-1:0]       fr_low;
	logic                dv_valid;
	tct_pkg::tct_flags_t dv_flags;
	logic [QW-1:0]       dv_quot;
	logic [QW-1:0]       mag;
	logic [TW-1:0]       time_d;
	logic                valid_q;
	logic [TW-1:0]       time_q;
	tct_pkg::tct_status_t status_q;

	// Advance everything unless a finished result is held
	assign en        = !valid_q || rsp.ready;
	assign req.ready = en;

	tct_front #(.CW(COORD_WIDTH), .FB(TIME_FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(req.valid),
		.sel(req.moving_sel),
		.x0(req.first_x), .y0(req.first_y),
		.x1(req.second_x), .y1(req.second_y),
		.x2(req.third_x), .y2(req.third_y),
		.dx(req.step_x), .dy(req.step_y),
		.valid_s5(fr_valid), .flags_s5(fr_flags),
		.rem_s5(fr_rem), .low_s5(fr_low), .den_s5(fr_den)
	);

	tct_div #(.NW(NW)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(fr_valid),
		.in_flags(fr_flags), .in_rem(fr_rem), .in_low(fr_low), .in_den(fr_den),
		.out_valid(dv_valid), .out_flags(dv_flags), .out_quot(dv_quot)
	);

	// Round half away from zero, then saturate
	assign mag = QW'(({1'b0, dv_quot} + (QW+1)'(1)) >> 1);

	always_comb begin
		unique case (dv_flags.status)
			tct_pkg::ST_NOT_IN:    time_d = TW'(-(64'sd1 <<< TIME_FRAC_BITS));
			tct_pkg::ST_AREA_ZERO: time_d = '0;
			tct_pkg::ST_DEN_ZERO:  time_d = {1'b0, {(TW-1){1'b1}}};
			default: begin
				if (!dv_flags.neg) begin
					if (dv_flags.sat || mag[QW-1] || mag[TW-1])
						time_d = {1'b0, {(TW-1){1'b1}}};
					else
						time_d = mag[TW-1:0];
				end else begin
					if (dv_flags.sat || mag[QW-1] || (mag[TW-1] && mag[TW-2:0] != '0))
						time_d = {1'b1, {(TW-1){1'b0}}};
					else
						time_d = TW'(-mag[TW-1:0]);
				end
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			time_q   <= time_d;
			status_q <= dv_flags.status;
		end
	end

	assign rsp.valid         = valid_q;
	assign rsp.collapse_time = time_q;
	assign rsp.status        = status_q;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for triangle_collapse_time: directed table plus random
// triangles, each result checked against a typed-in answer or an in-bench predictor.
// Depends on tct_pkg, tct_req_if, tct_rsp_if and the RTL top.
module testbench;

	localparam int CW = tct_pkg::COORD_WIDTH;
	localparam int FB = tct_pkg::TIME_FRAC_BITS;
	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [31:0] T_MAXPOS = 32'h7FFF_FFFF;
	localparam logic [31:0] T_MAXNEG = 32'h8000_0000;
	localparam logic [31:0] T_MINUS1 = -(32'sd1 <<< FB);

	typedef struct packed {
		logic [1:0] sel;
		logic signed [CW-1:0] x0, y0, x1, y1, x2, y2, dx, dy;
	} tri_req_t;

	typedef struct packed {
		logic [31:0] tval;
		tct_pkg::tct_status_t st;
	} tri_rsp_t;

	// directed row: request, and a typed-in answer when use_fixed is set
	typedef struct packed {
		tri_req_t r;
		logic use_fixed;
		tri_rsp_t fixed;
	} dir_row_t;

	logic clk;
	logic arst_n;
	bit failed;
	int send_idle_pct, recv_idle_pct;
	tri_rsp_t expected_q[$];

	tct_req_if req ();
	tct_rsp_if rsp ();

	triangle_collapse_time u_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// compute collapse time and status for one triangle
	function automatic tri_rsp_t collapse_of(tri_req_t r);
		logic signed [CW:0] ax, ay, bx, by, cx, cy;
		logic signed [127:0] area0, den, nm, dm, q, mag;
		bit neg;
		tri_rsp_t o;
		case (r.sel)
			tct_pkg::SEL_FIRST: begin
				ax = r.x1; ay = r.y1; bx = r.x2; by = r.y2; cx = r.x0; cy = r.y0;
			end
			tct_pkg::SEL_SECOND: begin
				ax = r.x0; ay = r.y0; bx = r.x2; by = r.y2; cx = r.x1; cy = r.y1;
			end
			default: begin
				ax = r.x0; ay = r.y0; bx = r.x1; by = r.y1; cx = r.x2; cy = r.y2;
			end
		endcase
		if (r.sel == tct_pkg::SEL_NONE) begin
			o.tval = T_MINUS1; o.st = tct_pkg::ST_NOT_IN;
			return o;
		end
		bx = bx - ax; by = by - ay; cx = cx - ax; cy = cy - ay;
		area0 = 128'(cx) * 128'(by) - 128'(cy) * 128'(bx);
		den = 128'(bx) * 128'(r.dy) - 128'(by) * 128'(r.dx);
		if (area0 == 0) begin
			o.tval = '0; o.st = tct_pkg::ST_AREA_ZERO;
			return o;
		end
		if (den == 0) begin
			o.tval = T_MAXPOS; o.st = tct_pkg::ST_DEN_ZERO;
			return o;
		end
		neg = (area0 < 0) ^ (den < 0);
		nm = (area0 < 0) ? -area0 : area0;
		dm = (den < 0) ? -den : den;
		q = (nm <<< (FB + 1)) / dm;
		mag = (q + 1) >>> 1;
		if (!neg) o.tval = (mag > 128'sh7FFF_FFFF) ? T_MAXPOS : mag[31:0];
		else o.tval = (mag > 128'sh8000_0000) ? T_MAXNEG : (-mag[31:0]);
		o.st = tct_pkg::ST_OK;
		return o;
	endfunction

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return CMAX;
			1: return CMIN;
			2: return CW'($signed($urandom_range(0, 40)) - 20);
			default: return CW'($urandom);
		endcase
	endfunction

	function automatic tri_req_t rand_triangle();
		tri_req_t r;
		r.sel = 2'($urandom_range(0, 3));
		r.x0 = rand_coord(); r.y0 = rand_coord();
		r.x1 = rand_coord(); r.y1 = rand_coord();
		r.x2 = rand_coord(); r.y2 = rand_coord();
		r.dx = rand_coord(); r.dy = rand_coord();
		// force some collinear or parallel-step cases
		case ($urandom_range(0, 9))
			0: begin r.x2 = r.x1; r.y2 = r.y1; end
			1: begin r.dx = '0; r.dy = '0; end
			2: begin r.x0 = r.x1; r.y0 = r.y1; end
			default: ;
		endcase
		return r;
	endfunction

	function automatic tri_req_t mk(logic [1:0] s, int a, int b, int c, int d,
			int e, int f, int g, int h);
		tri_req_t r;
		r.sel = s; r.x0 = CW'(a); r.y0 = CW'(b); r.x1 = CW'(c); r.y1 = CW'(d);
		r.x2 = CW'(e); r.y2 = CW'(f); r.dx = CW'(g); r.dy = CW'(h);
		return r;
	endfunction

	// drive one request and hold until accepted; drop valid while idling
	task automatic send_triangle(tri_req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.moving_sel <= r.sel;
		req.first_x <= r.x0; req.first_y <= r.y0;
		req.second_x <= r.x1; req.second_y <= r.y1;
		req.third_x <= r.x2; req.third_y <= r.y2;
		req.step_x <= r.dx; req.step_y <= r.dy;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic send_checked(tri_req_t r);
		expected_q.push_back(collapse_of(r));
		send_triangle(r);
	endtask

	// receiver: random stall, compare each accepted result
	always @(posedge clk) begin
		tri_rsp_t e;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result time=%h status=%0d", $time,
						rsp.collapse_time, rsp.status);
					failed = 1'b1;
				end else begin
					e = expected_q.pop_front();
					if (rsp.collapse_time !== e.tval) begin
						$display("%0t: collapse_time expected %h actual %h", $time,
							e.tval, rsp.collapse_time);
						failed = 1'b1;
					end
					if (rsp.status !== e.st) begin
						$display("%0t: status expected %0d actual %0d", $time, e.st,
							rsp.status);
						failed = 1'b1;
					end
				end
			end
			rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		#200000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		dir_row_t dir_tab[$];
		dir_row_t row;
		int n;
		failed = 1'b0;
		send_idle_pct = 12;
		recv_idle_pct = 48;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.moving_sel = tct_pkg::SEL_FIRST;
		{req.first_x, req.first_y, req.second_x, req.second_y} = '0;
		{req.third_x, req.third_y, req.step_x, req.step_y} = '0;
		rsp.ready = 1'b0;

		// directed rows: fixed answers for special cases, predictor elsewhere
		dir_tab.push_back('{mk(tct_pkg::SEL_NONE, 1, 2, 3, 4, 5, 6, 7, 8), 1'b1,
			'{T_MINUS1, tct_pkg::ST_NOT_IN}});
		dir_tab.push_back('{mk(tct_pkg::SEL_FIRST, 0, 0, 1, 1, 2, 2, 3, 5), 1'b1,
			'{32'h0, tct_pkg::ST_AREA_ZERO}});
		dir_tab.push_back('{mk(tct_pkg::SEL_THIRD, 0, 0, 4, 0, 0, 4, 8, 0), 1'b1,
			'{T_MAXPOS, tct_pkg::ST_DEN_ZERO}});
		dir_tab.push_back('{mk(tct_pkg::SEL_THIRD, 0, 0, 4, 0, 0, 4, 0, -8), 1'b0, '0});
		dir_tab.push_back('{mk(tct_pkg::SEL_SECOND, 0, 0, 0, 4, 4, 0, -3, 1), 1'b0, '0});
		dir_tab.push_back('{mk(tct_pkg::SEL_FIRST, 0, 4, 0, 0, 4, 0, 0, 1), 1'b0, '0});
		dir_tab.push_back('{mk(tct_pkg::SEL_THIRD, 0, 0, 1, 0, 0, 1000000, 0, 1),
			1'b0, '0});
		dir_tab.push_back('{mk(tct_pkg::SEL_THIRD, 0, 0, 1, 0, 0, 1000000, 0, -1),
			1'b0, '0});
		dir_tab.push_back('{mk(tct_pkg::SEL_THIRD, 0, 0, 3, 0, 0, 1, 0, -3), 1'b0, '0});
		row = '{mk(tct_pkg::SEL_FIRST, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
		row.r.x0 = CMAX; row.r.y0 = CMAX; row.r.x1 = CMIN; row.r.y1 = CMIN;
		row.r.x2 = CMIN; row.r.y2 = CMAX; row.r.dx = CMIN; row.r.dy = CMAX;
		dir_tab.push_back(row);
		row.r.sel = tct_pkg::SEL_SECOND; row.r.dx = CMAX; row.r.dy = CMIN;
		dir_tab.push_back(row);
		row.r.sel = tct_pkg::SEL_THIRD; row.r.x0 = CMIN; row.r.y1 = CMAX;
		row.r.dx = CW'(1);
		dir_tab.push_back(row);
		row.r = '{tct_pkg::SEL_NONE, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN};
		row.use_fixed = 1'b1; row.fixed = '{T_MINUS1, tct_pkg::ST_NOT_IN};
		dir_tab.push_back(row);
		row.r = '{tct_pkg::SEL_SECOND, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX};
		row.fixed = '{32'h0, tct_pkg::ST_AREA_ZERO};
		dir_tab.push_back(row);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].use_fixed) begin
				expected_q.push_back(dir_tab[i].fixed);
				send_triangle(dir_tab[i].r);
			end else send_checked(dir_tab[i].r);
		end
		req.valid <= 1'b0;

		// hold the sender until the pipeline drains
		while (expected_q.size() != 0) @(posedge clk);

		for (n = 0; n < 500; n++) begin
			if (n == 170) begin
				send_idle_pct = 48; recv_idle_pct = 12;
			end else if (n == 340) begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end
			send_checked(rand_triangle());
		end
		req.valid <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (!failed) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end
endmodule
